// ----- hw/rtl/bpc_pkg.sv -----
// Shared types and constants for the button press classifier.
// Holds the sample and event word layouts, configuration fields and codes.
// No dependencies; every other file refers to it by scoped names.
package bpc_pkg;

  // Widths fixed by the word formats.
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned FIRED_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Event kinds; the kind code is also its bit in the fired mask.
  typedef enum logic [1:0] {
    KIND_SHORT     = 2'd0,
    KIND_LONG      = 2'd1,
    KIND_VERY_LONG = 2'd2
  } bpc_kind_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN_TIME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX_TIME = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VERY_LONG_TIME = 3'd5;

  // Configuration reset values.
  localparam logic [3:0]            RST_SLOTS_IN_USE   = 4'd8;
  localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE_TIME  = 16'd30;
  localparam logic [CFG_DATA_W-1:0] RST_SHORT_MIN_TIME = 16'd40;
  localparam logic [CFG_DATA_W-1:0] RST_SHORT_MAX_TIME = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] RST_LONG_TIME      = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] RST_VERY_LONG_TIME = 16'd6000;

  // Configuration register set.
  typedef struct packed {
    logic [3:0]            slots_in_use;
    logic [CFG_DATA_W-1:0] debounce_time;
    logic [CFG_DATA_W-1:0] short_min_time;
    logic [CFG_DATA_W-1:0] short_max_time;
    logic [CFG_DATA_W-1:0] long_time;
    logic [CFG_DATA_W-1:0] very_long_time;
  } bpc_cfg_t;

  // Input word: one sample of one slot.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              level_pressed;
    logic [NOW_W-1:0]  now_ms;
  } bpc_in_t;

  // Output word: one press event.
  typedef struct packed {
    logic [SLOT_W-1:0] event_slot;
    logic [1:0]        event_kind;
  } bpc_out_t;

endpackage

// ----- hw/rtl/bpc_classify.sv -----
// Per-sample debounce and press classification for one slot's state.
// Pure combinational next-state and event logic; the caller holds the state.
// Depends on bpc_pkg.
module bpc_classify #(
  parameter int unsigned NUM_SLOTS = 8,
  parameter int unsigned TIME_BITS = 32
) (
  input  bpc_pkg::bpc_cfg_t                cfg_i,
  input  bpc_pkg::bpc_in_t                 sample_i,
  input  logic                             raw_i,
  input  logic                             deb_i,
  input  logic [TIME_BITS-1:0]             chg_i,
  input  logic [TIME_BITS-1:0]             ps_i,
  input  logic [bpc_pkg::FIRED_W-1:0]      fired_i,
  output logic                             upd_o,
  output logic                             raw_o,
  output logic                             deb_o,
  output logic [TIME_BITS-1:0]             chg_o,
  output logic [TIME_BITS-1:0]             ps_o,
  output logic [bpc_pkg::FIRED_W-1:0]      fired_o,
  output logic                             evt_vld_o,
  output bpc_pkg::bpc_kind_e               evt_kind_o
);

  localparam logic [6:0] NUM_SLOTS_V = 7'(NUM_SLOTS);

  logic                 slot_ok;
  logic                 lvl;
  logic                 changed;
  logic                 stable;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] since_chg;
  logic [TIME_BITS-1:0] held;
  logic                 evt_vld;

  // A slot counts only when it is enabled and exists.
  assign slot_ok = ({1'b0, sample_i.slot} < cfg_i.slots_in_use) &&
                   ({4'd0, sample_i.slot} < NUM_SLOTS_V);
  assign upd_o   = slot_ok;

  // Time differences wrap at the width of the time registers.
  assign lvl       = sample_i.level_pressed;
  assign now_t     = TIME_BITS'(sample_i.now_ms);
  assign changed   = (lvl != raw_i);
  assign since_chg = now_t - chg_i;
  assign held      = now_t - ps_i;
  assign stable    = (since_chg >= TIME_BITS'(cfg_i.debounce_time));

  // Debounce state update and event selection.
  always_comb begin
    raw_o      = raw_i;
    deb_o      = deb_i;
    chg_o      = chg_i;
    ps_o       = ps_i;
    fired_o    = fired_i;
    evt_vld    = 1'b0;
    evt_kind_o = bpc_pkg::KIND_SHORT;
    if (changed) begin
      // A new raw level only restarts the debounce timer.
      raw_o = lvl;
      chg_o = now_t;
    end else if (stable) begin
      if (lvl && !deb_i) begin
        // Debounced press: start the hold and clear the fired mask.
        deb_o   = 1'b1;
        ps_o    = now_t;
        fired_o = '0;
      end else if (!lvl && deb_i) begin
        // Debounced release: short press if the hold fits and nothing fired.
        deb_o = 1'b0;
        if ((held >= TIME_BITS'(cfg_i.short_min_time)) &&
            (held <  TIME_BITS'(cfg_i.short_max_time)) &&
            (fired_i == '0)) begin
          evt_vld    = 1'b1;
          evt_kind_o = bpc_pkg::KIND_SHORT;
        end
      end else if (lvl && deb_i) begin
        // Held: very long takes precedence over long.
        if ((held >= TIME_BITS'(cfg_i.very_long_time)) &&
            !fired_i[bpc_pkg::KIND_VERY_LONG]) begin
          evt_vld    = 1'b1;
          evt_kind_o = bpc_pkg::KIND_VERY_LONG;
        end else if ((held >= TIME_BITS'(cfg_i.long_time)) &&
                     !fired_i[bpc_pkg::KIND_LONG]) begin
          evt_vld    = 1'b1;
          evt_kind_o = bpc_pkg::KIND_LONG;
        end
      end
    end
    if (evt_vld) begin
      fired_o = fired_o | (bpc_pkg::FIRED_W'(1) << evt_kind_o);
    end
  end

  assign evt_vld_o = evt_vld && slot_ok;

endmodule

// ----- hw/rtl/button_press_classifier_top.sv -----
// Top level of the button press classifier: channels, registers, slot state.
// Instantiates bpc_classify; depends on bpc_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) carries one sample
//   word per slot: slot index, pressed bit and millisecond time. Output
//   channel (out_valid_o / out_stall_i / out_word_o) carries a press event
//   word: slot and kind (short, long, very long). A sample yields zero or
//   one event.
//   A word accepted on the input sits in the input register and is then
//   classified against the slot's stored state; that state is updated at
//   the same edge at which any event is loaded into the output register.
//   Unless an event waits on a stalled output, one word per cycle is
//   sustained, set by the single read-modify-write of per-slot state.
//   When the receiver stalls, the event waits in the output register; one
//   more sample is held in the input register, and the input stalls only
//   when that sample would produce a second event.
//   Reset clears all slots to released with zero times and restores the
//   default configuration; no warm-up pass is needed. The configuration
//   channel is always ready and should be written only while idle.
module button_press_classifier_top #(
  parameter int unsigned NUM_SLOTS = 8,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bpc_pkg::bpc_in_t                  in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bpc_pkg::bpc_out_t                 out_word_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  bpc_pkg::bpc_cfg_t cfg_q;

  bpc_pkg::bpc_in_t  in_q;
  logic              in_vld_q;
  logic              in_vld_d;
  bpc_pkg::bpc_out_t out_q;
  logic              out_vld_q;
  logic              out_vld_d;

  logic                        raw_q   [NUM_SLOTS];
  logic                        deb_q   [NUM_SLOTS];
  logic [TIME_BITS-1:0]        chg_q   [NUM_SLOTS];
  logic [TIME_BITS-1:0]        ps_q    [NUM_SLOTS];
  logic [bpc_pkg::FIRED_W-1:0] fired_q [NUM_SLOTS];

  logic [IDX_W-1:0]            rd_idx;
  logic                        upd;
  logic                        raw_d;
  logic                        deb_d;
  logic [TIME_BITS-1:0]        chg_d;
  logic [TIME_BITS-1:0]        ps_d;
  logic [bpc_pkg::FIRED_W-1:0] fired_d;
  logic                        evt_vld;
  bpc_pkg::bpc_kind_e          evt_kind;
  logic                        proc;
  logic                        in_acc;

  // Configuration registers; writes beyond the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slots_in_use   <= bpc_pkg::RST_SLOTS_IN_USE;
      cfg_q.debounce_time  <= bpc_pkg::RST_DEBOUNCE_TIME;
      cfg_q.short_min_time <= bpc_pkg::RST_SHORT_MIN_TIME;
      cfg_q.short_max_time <= bpc_pkg::RST_SHORT_MAX_TIME;
      cfg_q.long_time      <= bpc_pkg::RST_LONG_TIME;
      cfg_q.very_long_time <= bpc_pkg::RST_VERY_LONG_TIME;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bpc_pkg::CFG_SLOTS_IN_USE:   cfg_q.slots_in_use   <= cfg_data_i[3:0];
        bpc_pkg::CFG_DEBOUNCE_TIME:  cfg_q.debounce_time  <= cfg_data_i;
        bpc_pkg::CFG_SHORT_MIN_TIME: cfg_q.short_min_time <= cfg_data_i;
        bpc_pkg::CFG_SHORT_MAX_TIME: cfg_q.short_max_time <= cfg_data_i;
        bpc_pkg::CFG_LONG_TIME:      cfg_q.long_time      <= cfg_data_i;
        bpc_pkg::CFG_VERY_LONG_TIME: cfg_q.very_long_time <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Read the addressed slot; out-of-range slots are masked by the classifier.
  assign rd_idx = IDX_W'(in_q.slot);

  bpc_classify #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_classify (
    .cfg_i      (cfg_q),
    .sample_i   (in_q),
    .raw_i      (raw_q[rd_idx]),
    .deb_i      (deb_q[rd_idx]),
    .chg_i      (chg_q[rd_idx]),
    .ps_i       (ps_q[rd_idx]),
    .fired_i    (fired_q[rd_idx]),
    .upd_o      (upd),
    .raw_o      (raw_d),
    .deb_o      (deb_d),
    .chg_o      (chg_d),
    .ps_o       (ps_d),
    .fired_o    (fired_d),
    .evt_vld_o  (evt_vld),
    .evt_kind_o (evt_kind)
  );

  // The held word is processed unless its event would find the output full.
  assign proc       = in_vld_q && (!out_vld_q || !out_stall_i || !evt_vld);
  assign in_stall_o = in_vld_q && !proc;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_acc ? 1'b1 : (proc ? 1'b0 : in_vld_q);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_word_i;
    end
  end

  // Per-slot state, cleared to released at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        raw_q[i]   <= 1'b0;
        deb_q[i]   <= 1'b0;
        chg_q[i]   <= '0;
        ps_q[i]    <= '0;
        fired_q[i] <= '0;
      end
    end else if (proc && upd) begin
      raw_q[rd_idx]   <= raw_d;
      deb_q[rd_idx]   <= deb_d;
      chg_q[rd_idx]   <= chg_d;
      ps_q[rd_idx]    <= ps_d;
      fired_q[rd_idx] <= fired_d;
    end
  end

  // Output register holds an event until the receiver takes it.
  assign out_vld_d = (proc && evt_vld) ? 1'b1 : (out_stall_i ? out_vld_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && evt_vld) begin
      out_q.event_slot <= in_q.slot;
      out_q.event_kind <= evt_kind;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  // An event carries the slot of the sample that caused it.
  a_evt_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && evt_vld) |=> (out_vld_q && out_q.event_slot == $past(in_q.slot)))
    else $error("event slot does not match its sample");

  // After an event, its kind is marked fired for that slot.
  a_evt_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && evt_vld) |=> fired_q[$past(rd_idx)][out_q.event_kind])
    else $error("fired mask not updated after event");

  // A slot out of use never produces an event.
  a_no_evt_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !upd) |-> !evt_vld)
    else $error("event from a slot out of use");

  // A held sample that is not processed stays in the input register.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !proc) |=> (in_vld_q && $stable(in_q)))
    else $error("held sample lost or changed");
`endif

endmodule

// ----- dv/button_press_classifier_top_tb.sv -----
// Self-checking testbench for button_press_classifier_top.
// Runs a short scripted sequence and then random debounce and hold traffic, and checks
// every event word against the script or a local model of the slot state; depends on bpc_pkg and the top.
module button_press_classifier_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF        = 10;
  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned SLOT_COUNT      = 8;
  localparam int unsigned PIPE_LATENCY    = 2;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned MAX_GAP         = 40;
  localparam int unsigned MAX_PRINTED     = 100;
  localparam int unsigned PHASE_COUNT     = 11;
  localparam int unsigned PHASE_WORDS     = 165;
  localparam int unsigned IDLE_WORDS      = 16;
  // Index beyond the register list; a write there must change nothing.
  localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

  // One line of the scripted sequence: either a register write or a sample word.
  // When fixed is set, the expected event is the one typed in the line.
  typedef struct packed {
    logic                           is_reg;
    logic [bpc_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [bpc_pkg::CFG_DATA_W-1:0] reg_data;
    logic [bpc_pkg::SLOT_W-1:0]     slot;
    logic                           pressed;
    logic [bpc_pkg::NOW_W-1:0]      now_ms;
    logic                           fixed;
    logic                           fires;
    bpc_pkg::bpc_kind_e             kind;
  } script_row_t;

  localparam int unsigned SCRIPT_LEN = 31;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // Slot 0 after reset: press, debounce, release, short press.
    '{1'b0, 3'd0, 16'd0, 3'd0, 1'b1, 32'd100, 1'b1, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd0, 1'b1, 32'd130, 1'b1, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd0, 1'b0, 32'd200, 1'b1, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd0, 1'b0, 32'd230, 1'b1, 1'b1, bpc_pkg::KIND_SHORT},
    // Slot 1: long at 2000 ms of hold, very long at 6000 ms.
    '{1'b0, 3'd0, 16'd0, 3'd1, 1'b1, 32'd1000, 1'b1, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd1, 1'b1, 32'd1030, 1'b1, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd1, 1'b1, 32'd3030, 1'b1, 1'b1, bpc_pkg::KIND_LONG},
    '{1'b0, 3'd0, 16'd0, 3'd1, 1'b1, 32'd7030, 1'b1, 1'b1, bpc_pkg::KIND_VERY_LONG},
    // Slot 2: both due at once, very long first and long on the next sample.
    '{1'b0, 3'd0, 16'd0, 3'd2, 1'b1, 32'd0, 1'b1, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd2, 1'b1, 32'd40, 1'b1, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd2, 1'b1, 32'd7000, 1'b1, 1'b1, bpc_pkg::KIND_VERY_LONG},
    '{1'b0, 3'd0, 16'd0, 3'd2, 1'b1, 32'd7001, 1'b1, 1'b1, bpc_pkg::KIND_LONG},
    // Slot 3: a level change swallows a long hold that is due.
    '{1'b0, 3'd0, 16'd0, 3'd3, 1'b1, 32'd50, 1'b0, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd3, 1'b1, 32'd80, 1'b0, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd3, 1'b0, 32'd5000, 1'b1, 1'b0, bpc_pkg::KIND_SHORT},
    // Slot 4: the millisecond time wraps during the press.
    '{1'b0, 3'd0, 16'd0, 3'd4, 1'b1, 32'hFFFF_FFF0, 1'b0, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd4, 1'b1, 32'h0000_000E, 1'b0, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd4, 1'b0, 32'h0000_0020, 1'b0, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd4, 1'b0, 32'h0000_003E, 1'b1, 1'b1, bpc_pkg::KIND_SHORT},
    // Top slot at the top of the time range.
    '{1'b0, 3'd0, 16'd0, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, bpc_pkg::KIND_SHORT},
    // Writes to an index past the list are dropped.
    '{1'b1, CFG_SPARE, 16'hFFFF, 3'd0, 1'b0, 32'd0, 1'b0, 1'b0, bpc_pkg::KIND_SHORT},
    // Only three slots in use; the upper data bits are dropped.
    '{1'b1, bpc_pkg::CFG_SLOTS_IN_USE, 16'hFFF3, 3'd0, 1'b0, 32'd0, 1'b0, 1'b0,
      bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd5, 1'b1, 32'h0000_1234, 1'b1, 1'b0, bpc_pkg::KIND_SHORT},
    // A count above eight enables every slot again.
    '{1'b1, bpc_pkg::CFG_SLOTS_IN_USE, 16'h000C, 3'd0, 1'b0, 32'd0, 1'b0, 1'b0,
      bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd7, 1'b1, 32'h0000_001D, 1'b0, 1'b0, bpc_pkg::KIND_SHORT},
    // Short window upside down: no short press is possible.
    '{1'b1, bpc_pkg::CFG_SHORT_MIN_TIME, 16'd500, 3'd0, 1'b0, 32'd0, 1'b0, 1'b0,
      bpc_pkg::KIND_SHORT},
    '{1'b1, bpc_pkg::CFG_SHORT_MAX_TIME, 16'd100, 3'd0, 1'b0, 32'd0, 1'b0, 1'b0,
      bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd0, 1'b1, 32'd10000, 1'b0, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd0, 1'b1, 32'd10030, 1'b0, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd0, 1'b0, 32'd10040, 1'b0, 1'b0, bpc_pkg::KIND_SHORT},
    '{1'b0, 3'd0, 16'd0, 3'd0, 1'b0, 32'd10300, 1'b1, 1'b0, bpc_pkg::KIND_SHORT}
  };

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  bpc_pkg::bpc_in_t               in_word;
  logic                           out_valid;
  logic                           out_stall;
  bpc_pkg::bpc_out_t              out_word;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data;

  // Model of the register set and of every slot.
  bpc_pkg::bpc_cfg_t cfg_model;
  logic        raw_lvl     [SLOT_COUNT];
  logic [31:0] chg_time    [SLOT_COUNT];
  logic        deb_pressed [SLOT_COUNT];
  logic [31:0] press_time  [SLOT_COUNT];
  logic [2:0]  fired       [SLOT_COUNT];

  bpc_pkg::bpc_out_t pending_events [$];
  bpc_pkg::bpc_out_t oldest_event;
  int       errors = 0;
  int       quiet_cycles = 0;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       hold_requests = 0;
  int       hold_seen = 0;
  int       hold_left = 0;

  button_press_classifier_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Classify one accepted sample word and update the slot model.
  // Returns 1 when the word produces an event, which is placed in ev.
  function automatic bit classify_sample(input bpc_pkg::bpc_in_t w,
                                         output bpc_pkg::bpc_out_t ev);
    logic [2:0]         s;
    logic [31:0]        since_change;
    logic [31:0]        held;
    bpc_pkg::bpc_kind_e kind;
    bit                 fire;
    s = w.slot;
    fire = 1'b0;
    kind = bpc_pkg::KIND_SHORT;
    ev = '0;
    if ({1'b0, s} >= cfg_model.slots_in_use) return 1'b0;
    // A new raw level only restarts the debounce timer.
    if (w.level_pressed != raw_lvl[s]) begin
      raw_lvl[s] = w.level_pressed;
      chg_time[s] = w.now_ms;
      return 1'b0;
    end
    since_change = w.now_ms - chg_time[s];
    if (since_change < {16'd0, cfg_model.debounce_time}) return 1'b0;
    held = w.now_ms - press_time[s];
    if (w.level_pressed && !deb_pressed[s]) begin
      deb_pressed[s] = 1'b1;
      press_time[s] = w.now_ms;
      fired[s] = 3'd0;
    end else if (!w.level_pressed && deb_pressed[s]) begin
      deb_pressed[s] = 1'b0;
      if (held >= {16'd0, cfg_model.short_min_time} &&
          held < {16'd0, cfg_model.short_max_time} && fired[s] == 3'd0) begin
        fire = 1'b1;
        kind = bpc_pkg::KIND_SHORT;
      end
    end else if (w.level_pressed && deb_pressed[s]) begin
      // Very long wins when both thresholds are reached at once.
      if (held >= {16'd0, cfg_model.very_long_time} &&
          !fired[s][bpc_pkg::KIND_VERY_LONG]) begin
        fire = 1'b1;
        kind = bpc_pkg::KIND_VERY_LONG;
      end else if (held >= {16'd0, cfg_model.long_time} &&
                   !fired[s][bpc_pkg::KIND_LONG]) begin
        fire = 1'b1;
        kind = bpc_pkg::KIND_LONG;
      end
    end
    if (!fire) return 1'b0;
    fired[s][kind] = 1'b1;
    ev.event_slot = s;
    ev.event_kind = kind;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Offer one sample word after a random gap and record its expected event.
  task automatic send_sample(input bpc_pkg::bpc_in_t word, input bit fixed, input bit fires,
                             input bpc_pkg::bpc_kind_e kind);
    int                gap;
    bpc_pkg::bpc_out_t ev;
    bit                hit;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hit = classify_sample(word, ev);
    if (fixed) begin
      if (fires) begin
        ev.event_slot = word.slot;
        ev.event_kind = kind;
        pending_events.push_back(ev);
      end
    end else if (hit) begin
      pending_events.push_back(ev);
    end
  endtask

  // Stop offering words and wait until every expected event has come out,
  // plus the pipeline depth for samples that produce nothing.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // One register write; the caller lowers cfg_valid after its last write.
  task automatic write_reg(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bpc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bpc_pkg::CFG_SLOTS_IN_USE:   cfg_model.slots_in_use = data[3:0];
      bpc_pkg::CFG_DEBOUNCE_TIME:  cfg_model.debounce_time = data;
      bpc_pkg::CFG_SHORT_MIN_TIME: cfg_model.short_min_time = data;
      bpc_pkg::CFG_SHORT_MAX_TIME: cfg_model.short_max_time = data;
      bpc_pkg::CFG_LONG_TIME:      cfg_model.long_time = data;
      bpc_pkg::CFG_VERY_LONG_TIME: cfg_model.very_long_time = data;
      default: ;
    endcase
  endtask

  // Pick the settings of one random phase and stream button traffic through them.
  // Focus slots get well-formed presses and releases with held times spread over
  // the thresholds; the rest is stray slots, contact bounce and wild timestamps.
  task automatic run_phase(input int phase, input int target);
    bpc_pkg::bpc_cfg_t c;
    logic [31:0]       clock_ms;
    logic              intent   [SLOT_COUNT];
    logic [31:0]       deadline [SLOT_COUNT];
    logic [2:0]        focus    [2];
    logic [2:0]        s;
    int                in_use;
    int                step_max;
    int                fed;
    int                dur;
    bpc_pkg::bpc_in_t  word;
    c.slots_in_use   = 4'($urandom_range(1, 15));
    c.debounce_time  = 16'($urandom_range(0, 300));
    c.short_min_time = 16'($urandom_range(0, 2000));
    c.short_max_time = 16'($urandom_range(0, 4000));
    c.long_time      = 16'($urandom_range(0, 8000));
    c.very_long_time = 16'($urandom_range(0, 12000));
    case (phase)
      0: c = '{bpc_pkg::RST_SLOTS_IN_USE, bpc_pkg::RST_DEBOUNCE_TIME,
               bpc_pkg::RST_SHORT_MIN_TIME, bpc_pkg::RST_SHORT_MAX_TIME,
               bpc_pkg::RST_LONG_TIME, bpc_pkg::RST_VERY_LONG_TIME};
      1: c = '{4'd15, 16'd0, 16'd0, 16'hFFFF, 16'd1, 16'd2};
      2: c = '{4'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      3: c.slots_in_use = 4'd0;
      4: c = '{4'd5, 16'd10, 16'd3000, 16'd200, 16'd100, 16'd50};
      5: c = '{4'd6, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0};
      default: ;
    endcase

    settle();
    write_reg(bpc_pkg::CFG_SLOTS_IN_USE, {12'($urandom), c.slots_in_use});
    write_reg(bpc_pkg::CFG_DEBOUNCE_TIME, c.debounce_time);
    write_reg(bpc_pkg::CFG_SHORT_MIN_TIME, c.short_min_time);
    write_reg(bpc_pkg::CFG_SHORT_MAX_TIME, c.short_max_time);
    write_reg(bpc_pkg::CFG_LONG_TIME, c.long_time);
    write_reg(bpc_pkg::CFG_VERY_LONG_TIME, c.very_long_time);
    @(negedge clk);
    cfg_valid <= 1'b0;

    in_use = (c.slots_in_use == 4'd0 || c.slots_in_use > SLOT_COUNT) ?
             SLOT_COUNT : int'(c.slots_in_use);
    focus[0] = 3'($urandom_range(0, in_use - 1));
    focus[1] = 3'($urandom_range(0, in_use - 1));
    step_max = c.debounce_time;
    if (c.very_long_time / 12 > step_max) step_max = c.very_long_time / 12;
    if (step_max < 8) step_max = 8;
    clock_ms = $urandom;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      intent[k] = 1'b0;
      deadline[k] = clock_ms;
    end

    fed = 0;
    while (fed < target) begin
      s = ($urandom_range(0, 99) < 80) ? focus[$urandom_range(0, 1)] :
                                          3'($urandom_range(0, 7));
      clock_ms += $urandom_range(0, step_max);
      // Flip the intended level once its planned duration is over.
      if ($signed(clock_ms - deadline[s]) >= 0) begin
        intent[s] = ~intent[s];
        case ($urandom_range(0, 4))
          0: dur = $urandom_range(0, c.short_min_time);
          1: dur = $urandom_range(c.short_min_time, c.short_max_time);
          2: dur = $urandom_range(c.short_max_time, c.long_time);
          3: dur = $urandom_range(c.long_time, c.very_long_time);
          default: dur = $urandom_range(c.very_long_time,
                                        c.very_long_time + c.long_time + 1);
        endcase
        deadline[s] = clock_ms + c.debounce_time + dur;
      end
      word.slot = s;
      word.level_pressed = intent[s] ^ ($urandom_range(0, 99) < 6);
      word.now_ms = ($urandom_range(0, 99) == 0) ? $urandom : clock_ms;
      send_sample(word, 1'b0, 1'b0, bpc_pkg::KIND_SHORT);
      if ({1'b0, s} < cfg_model.slots_in_use || cfg_model.slots_in_use == 4'd0) begin
        fed++;
        // Receiver holds off for a long stretch while samples keep coming.
        if (phase == 1 && fed == 60) hold_requests++;
        // Sender pauses until every expected event is out.
        if (phase == 6 && fed == 75) settle();
      end
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left == 0 && hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Event checker: each accepted event word must match the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event slot %0d kind %0d",
                                  out_word.event_slot, out_word.event_kind));
      end else begin
        oldest_event = pending_events.pop_front();
        if (out_word.event_slot != oldest_event.event_slot)
          report_mismatch($sformatf("event_slot %0d, expected %0d",
                                    out_word.event_slot, oldest_event.event_slot));
        if (out_word.event_kind != oldest_event.event_kind)
          report_mismatch($sformatf("event_kind %0d, expected %0d on slot %0d",
                                    out_word.event_kind, oldest_event.event_kind,
                                    oldest_event.event_slot));
      end
    end
  end

  // Watchdog: end the run when no channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL button_press_classifier_top");
      $finish;
    end
  end

  initial begin
    bpc_pkg::bpc_in_t word;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 24;
    recv_idle_pct = 58;

    // Model state after reset: default registers, every slot released.
    cfg_model = '{bpc_pkg::RST_SLOTS_IN_USE, bpc_pkg::RST_DEBOUNCE_TIME,
                  bpc_pkg::RST_SHORT_MIN_TIME, bpc_pkg::RST_SHORT_MAX_TIME,
                  bpc_pkg::RST_LONG_TIME, bpc_pkg::RST_VERY_LONG_TIME};
    for (int k = 0; k < SLOT_COUNT; k++) begin
      raw_lvl[k] = 1'b0;
      chg_time[k] = '0;
      deb_pressed[k] = 1'b0;
      press_time[k] = '0;
      fired[k] = '0;
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Scripted sequence.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].is_reg) begin
        settle();
        write_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_data);
        @(negedge clk);
        cfg_valid <= 1'b0;
      end else begin
        word.slot = SCRIPT[i].slot;
        word.level_pressed = SCRIPT[i].pressed;
        word.now_ms = SCRIPT[i].now_ms;
        send_sample(word, SCRIPT[i].fixed, SCRIPT[i].fires, SCRIPT[i].kind);
      end
    end

    // Random phases: sender-light idling, then receiver-light, then none.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == 4) begin
        send_idle_pct = 58;
        recv_idle_pct = 24;
      end
      if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_phase(p, (p == 3) ? IDLE_WORDS : PHASE_WORDS);
    end

    settle();
    if (errors == 0) begin
      $display("PASS button_press_classifier_top");
    end else begin
      $display("FAIL button_press_classifier_top");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_classify.sv
hw/rtl/button_press_classifier_top.sv
dv/button_press_classifier_top_tb.sv
